/* hdl/mtep_pkg.sv */
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants for the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

   // Default width of the track position and length registers
   localparam int LENGTH_BITS_DEF = 24;

   // Widths of the fixed fields
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_STATUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAD_DELTA = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_LEN  = 2'd2;

   // Byte codes
   localparam logic [7:0] META_END     = 8'h2F;
   localparam logic [7:0] META_TEMPO   = 8'h51;
   localparam logic [7:0] STATUS_SYSEX = 8'hF0;
   localparam logic [7:0] STATUS_META  = 8'hFF;
   localparam logic [3:0] NIB_PROG     = 4'hC;
   localparam logic [3:0] NIB_PRESS    = 4'hD;
   localparam logic [3:0] NIB_SYSTEM   = 4'hF;
   localparam logic [3:0] NIB_NOTE_OFF = 4'h8;

   // Parse phase, one-hot
   typedef enum logic [8:0] {
      PH_START     = 9'b000000001,
      PH_DELTA     = 9'b000000010,
      PH_STATUS    = 9'b000000100,
      PH_DATA1     = 9'b000001000,
      PH_DATA2     = 9'b000010000,
      PH_META_TYPE = 9'b000100000,
      PH_META_LEN  = 9'b001000000,
      PH_SYS_LEN   = 9'b010000000,
      PH_SKIP      = 9'b100000000
   } phase_type;

   // Result kind codes
   typedef enum logic [2:0] {
      KIND_CHAN        = 3'd0,
      KIND_TEMPO       = 3'd1,
      KIND_SYSEX_START = 3'd2,
      KIND_SYSEX_BYTE  = 3'd3,
      KIND_END         = 3'd4
   } kind_type;

   // One result beat
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  status;
      logic [7:0]  first;
      logic [7:0]  second;
      logic [1:0]  count;
      logic [31:0] delta;
      logic [23:0] tempo;
      logic [31:0] sysex_len;
   } event_type;

   // Mode flags from the configuration registers
   typedef struct packed {
      logic run_status_en;
      logic lead_delta_en;
   } flags_type;

endpackage

/* hdl/mtep_csr.sv */
// ----------------------------------------------------------------------------
// mtep_csr
// Configuration registers: running status, leading delta and track length.
// ----------------------------------------------------------------------------
module mtep_csr
   import mtep_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output flags_type              flags,
   output logic [LENGTH_BITS-1:0] track_len
);

   flags_type              flags_ff, flags_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [31:0]            wdata_ext;

   // Keep only the low bits of the written length that fit the position
   assign wdata_ext = 32'(csr_wdata);

   always_comb begin
      flags_in = flags_ff;
      len_in   = len_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RUN_STATUS: flags_in.run_status_en = csr_wdata[0];
            CSR_LEAD_DELTA: flags_in.lead_delta_en = csr_wdata[0];
            CSR_TRACK_LEN:  len_in = wdata_ext[LENGTH_BITS-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '{run_status_en: 1'b1, lead_delta_en: 1'b1};
         len_ff   <= '0;
      end else begin
         flags_ff <= flags_in;
         len_ff   <= len_in;
      end
   end

   assign flags     = flags_ff;
   assign track_len = len_ff;

endmodule

/* hdl/mtep_core.sv */
// ----------------------------------------------------------------------------
// mtep_core
// Parse state and the single-pass decode of one track byte.
// ----------------------------------------------------------------------------
module mtep_core
   import mtep_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  logic [7:0]             track_byte,
   input  flags_type              flags,
   input  logic [LENGTH_BITS-1:0] track_len,
   output logic                   emit,
   output event_type              ev
);

   localparam int POS_W = LENGTH_BITS + 1;
   localparam int SUM_W = 33;

   logic [LENGTH_BITS-1:0] pos_ff, pos_in, pos_adv;
   phase_type              phase_ff, phase_in;
   logic [7:0]             cur_ff, cur_in;
   logic [31:0]            la_ff, la_in;
   logic [31:0]            delta_ff, delta_in;
   logic [7:0]             held_ff, held_in;
   logic [7:0]             meta_ff, meta_in;
   logic [23:0]            tempo_ff, tempo_in;
   logic [31:0]            skip_ff, skip_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   ended_ff, ended_in;
   logic                   short_left;

   // Saturating position advance and the short remainder check
   assign pos_adv    = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
   assign short_left = (POS_W'(pos_ff) + POS_W'(3)) > POS_W'(track_len);

   always_comb begin
      phase_type   p1;
      phase_type   p2;
      logic        more;
      logic        taken;
      logic        is_meta;
      logic        vlq_done;
      logic        len_end;
      logic        last_byte;
      logic [7:0]  cur;
      logic [31:0] la_cur;
      logic [31:0] la_vlq;
      logic [32:0] dsum;
      logic [SUM_W-1:0] lsum;
      logic [23:0] tempo_new;

      pos_in   = pos_ff;
      phase_in = phase_ff;
      cur_in   = cur_ff;
      la_in    = la_ff;
      delta_in = delta_ff;
      held_in  = held_ff;
      meta_in  = meta_ff;
      tempo_in = tempo_ff;
      skip_in  = skip_ff;
      idx_in   = idx_ff;
      ended_in = ended_ff;
      emit     = 1'b0;
      ev       = '0;
      ev.delta = delta_ff;

      // Resolve the opening phase from the current mode
      p1     = phase_ff;
      la_cur = la_ff;
      if (phase_ff == PH_START) begin
         p1     = flags.lead_delta_en ? PH_DELTA : PH_STATUS;
         la_cur = '0;
      end
      cur   = cur_ff;
      p2    = p1;
      more  = 1'b1;
      taken = 1'b0;

      // Status byte: take it, or fall through with running status
      if (p1 == PH_STATUS) begin
         more = 1'b0;
         if (!short_left) begin
            taken = !flags.run_status_en || track_byte[7];
            if (taken) begin
               cur = track_byte;
            end
            la_cur = '0;
            if (cur[7:4] >= NIB_NOTE_OFF && cur[7:4] != NIB_SYSTEM) begin
               p2 = PH_DATA1;
            end else if (cur[7:4] == NIB_SYSTEM) begin
               p2 = (cur == STATUS_META) ? PH_META_TYPE : PH_SYS_LEN;
            end else begin
               p2 = PH_DELTA;
            end
            more = !taken;
         end
      end

      // Variable-length value step on this byte
      la_vlq   = {la_cur[24:0], track_byte[6:0]};
      vlq_done = !(track_byte[7] && (pos_adv < track_len));
      lsum     = SUM_W'(pos_adv) + SUM_W'(la_vlq);
      len_end  = lsum >= SUM_W'(track_len);
      dsum     = 33'(delta_ff) + 33'(la_vlq);
      is_meta  = (p2 == PH_META_LEN);
      last_byte = (skip_ff == 32'd1);
      tempo_new = tempo_ff;
      case (idx_ff)
         2'd0:    tempo_new = tempo_ff | {track_byte, 16'h0000};
         2'd1:    tempo_new = tempo_ff | {8'h00, track_byte, 8'h00};
         2'd2:    tempo_new = tempo_ff | {16'h0000, track_byte};
         default: tempo_new = tempo_ff;
      endcase

      if (go && !ended_ff) begin
         pos_in = pos_adv;
         cur_in = cur;
         la_in  = la_cur;
         if (p1 == PH_STATUS && short_left) begin
            // Too few bytes left for an event: end the track
            ended_in = 1'b1;
            emit     = 1'b1;
            ev.kind  = KIND_END;
         end else if (!more) begin
            phase_in = p2;
         end else begin
            case (p2)
               PH_DELTA: begin
                  la_in    = la_vlq;
                  phase_in = PH_DELTA;
                  if (vlq_done) begin
                     delta_in = dsum[32] ? 32'hFFFF_FFFF : dsum[31:0];
                     la_in    = '0;
                     phase_in = PH_STATUS;
                  end
               end
               PH_DATA1: begin
                  held_in = track_byte;
                  if (cur[7:4] == NIB_PROG || cur[7:4] == NIB_PRESS) begin
                     emit      = 1'b1;
                     ev.kind   = KIND_CHAN;
                     ev.status = cur;
                     ev.first  = track_byte;
                     ev.count  = 2'd1;
                     la_in     = '0;
                     phase_in  = PH_DELTA;
                  end else begin
                     phase_in = PH_DATA2;
                  end
               end
               PH_DATA2: begin
                  emit      = 1'b1;
                  ev.kind   = KIND_CHAN;
                  ev.status = cur;
                  ev.first  = held_ff;
                  ev.second = track_byte;
                  ev.count  = 2'd2;
                  la_in     = '0;
                  phase_in  = PH_DELTA;
               end
               PH_META_TYPE: begin
                  meta_in  = track_byte;
                  la_in    = '0;
                  phase_in = PH_META_LEN;
               end
               PH_META_LEN, PH_SYS_LEN: begin
                  la_in    = la_vlq;
                  phase_in = p2;
                  if (vlq_done) begin
                     if (len_end || (is_meta && meta_ff == META_END)) begin
                        ended_in = 1'b1;
                        emit     = 1'b1;
                        ev.kind  = KIND_END;
                     end else begin
                        skip_in  = la_vlq;
                        tempo_in = '0;
                        idx_in   = '0;
                        if (is_meta && meta_ff == META_TEMPO && la_vlq == '0) begin
                           emit      = 1'b1;
                           ev.kind   = KIND_TEMPO;
                           ev.status = STATUS_META;
                        end else if (!is_meta && cur == STATUS_SYSEX) begin
                           emit         = 1'b1;
                           ev.kind      = KIND_SYSEX_START;
                           ev.status    = cur;
                           ev.sysex_len = la_vlq;
                        end
                        phase_in = (la_vlq != '0) ? PH_SKIP : PH_DELTA;
                     end
                  end
               end
               PH_SKIP: begin
                  skip_in = skip_ff - 32'd1;
                  idx_in  = (idx_ff == 2'd3) ? idx_ff : idx_ff + 2'd1;
                  if (cur == STATUS_SYSEX) begin
                     emit      = 1'b1;
                     ev.kind   = KIND_SYSEX_BYTE;
                     ev.status = cur;
                     ev.first  = track_byte;
                  end else if (cur == STATUS_META && meta_ff == META_TEMPO &&
                               idx_ff != 2'd3) begin
                     tempo_in = tempo_new;
                     if (idx_ff == 2'd2 || last_byte) begin
                        emit      = 1'b1;
                        ev.kind   = KIND_TEMPO;
                        ev.status = STATUS_META;
                        ev.tempo  = tempo_new;
                     end
                  end
                  if (last_byte) begin
                     la_in    = '0;
                     phase_in = PH_DELTA;
                  end
               end
               default: begin
                  la_in    = '0;
                  phase_in = PH_DELTA;
               end
            endcase
         end
         // Restart the delta sum after every reported beat
         if (emit) begin
            delta_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PH_START;
         cur_ff   <= '0;
         la_ff    <= '0;
         delta_ff <= '0;
         held_ff  <= '0;
         meta_ff  <= '0;
         tempo_ff <= '0;
         skip_ff  <= '0;
         idx_ff   <= '0;
         ended_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         cur_ff   <= cur_in;
         la_ff    <= la_in;
         delta_ff <= delta_in;
         held_ff  <= held_in;
         meta_ff  <= meta_in;
         tempo_ff <= tempo_in;
         skip_ff  <= skip_in;
         idx_ff   <= idx_in;
         ended_ff <= ended_in;
      end
   end

   // An ended track stays ended until reset
   a_ended_sticky: assert property (@(posedge clock) disable iff (reset)
      ended_ff |=> ended_ff)
      else $error("track end flag dropped");

   // An end beat marks the track as ended
   a_end_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (go && emit && ev.kind == KIND_END) |=> ended_ff)
      else $error("end beat without end flag");

   // Every reported beat restarts the delta sum
   a_delta_restart: assert property (@(posedge clock) disable iff (reset)
      (go && emit) |=> (delta_ff == '0))
      else $error("delta sum not cleared after beat");

endmodule

/* hdl/mtep_out.sv */
// ----------------------------------------------------------------------------
// mtep_out
// Result register: holds one event beat until the sink takes it.
// ----------------------------------------------------------------------------
module mtep_out
   import mtep_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  event_type ev,
   input  logic      rsp_stall,
   output logic      rsp_valid,
   output event_type rsp_ev
);

   logic      valid_ff, valid_in;
   event_type ev_ff, ev_in;

   // Load a new beat, drop a taken one, else hold
   always_comb begin
      ev_in    = ev_ff;
      valid_in = valid_ff;
      if (load) begin
         ev_in    = ev;
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff <= ev_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_ev    = ev_ff;

   // Only channel messages carry a data byte count
   a_count_chan: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ((ev_ff.kind == KIND_CHAN) == (ev_ff.count != 2'd0)))
      else $error("data count on a non-channel beat");

   // Tempo field is zero except on tempo beats
   a_tempo_only: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && ev_ff.kind != KIND_TEMPO) |-> (ev_ff.tempo == '0))
      else $error("tempo value on a non-tempo beat");

endmodule

/* hdl/midi_track_event_parser.sv */
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Decodes a MIDI track chunk one byte per beat into channel, tempo, sysex
// and end-of-track events with the accumulated delta ticks.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------
//   req_     | in  | req_valid/stall    | track_byte
//   rsp_     | out | rsp_valid/stall    | event_kind .. sysex_length
//   csr_     | in  | csr_we, csr_index  | csr_wdata (24 bits)
//
// One byte per cycle while rsp_ is not stalled; a byte's result passes the
// input register, then the decode pass, into the result register.
// All parse state updates in the single decode pass, so no byte waits on
// the one before it.
// Reset is synchronous and returns the parser to the start of a track.
// A stall on rsp_ while the result register is full holds it and the input
// register; req_ stalls only while both are full.
//
module midi_track_event_parser
   import mtep_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_track_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_event_kind,
   output logic [7:0]            rsp_status_byte,
   output logic [7:0]            rsp_first_data,
   output logic [7:0]            rsp_second_data,
   output logic [1:0]            rsp_data_count,
   output logic [31:0]           rsp_delta_ticks,
   output logic [23:0]           rsp_tempo_usec,
   output logic [31:0]           rsp_sysex_length,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   flags_type              flags;
   logic [LENGTH_BITS-1:0] track_len;
   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff, in_byte_in;
   logic                   go;
   logic                   emit;
   event_type              ev;
   event_type              rsp_ev;

   mtep_csr #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .flags     (flags),
      .track_len (track_len)
   );

   // Decode the held byte when the result register is free or draining
   assign go        = in_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = in_valid_ff && !go;

   // Input register: take a new beat, drop a consumed one, else hold
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_track_byte;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   mtep_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .track_byte (in_byte_ff),
      .flags      (flags),
      .track_len  (track_len),
      .emit       (emit),
      .ev         (ev)
   );

   mtep_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (go && emit),
      .ev        (ev),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_ev    (rsp_ev)
   );

   // Spread the result beat onto its ports
   assign rsp_event_kind   = rsp_ev.kind;
   assign rsp_status_byte  = rsp_ev.status;
   assign rsp_first_data   = rsp_ev.first;
   assign rsp_second_data  = rsp_ev.second;
   assign rsp_data_count   = rsp_ev.count;
   assign rsp_delta_ticks  = rsp_ev.delta;
   assign rsp_tempo_usec   = rsp_ev.tempo;
   assign rsp_sysex_length = rsp_ev.sysex_len;

endmodule

/* tb/tb_midi_track_event_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_track_event_parser
// Feeds one MIDI track through the parser, byte by byte, and checks every
// event beat against a cycle-free decoder kept inside this bench. A directed
// opening covers channel, tempo and sysex events, running status, short tempo
// and delta saturation; four random phases mix well-formed events with noise
// under changing register settings; the run ends the track by one of the ways
// a track can end and then shows that later bytes are ignored.
// ----------------------------------------------------------------------------
module tb_midi_track_event_parser;
   import mtep_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_BYTES    = 460;

   typedef enum int {
      END_META,
      END_META_OVERRUN,
      END_SYSEX_OVERRUN,
      END_AT_ZERO_LENGTH,
      END_SHORT_REMAINDER
   } end_way_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_track_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [2:0]            rsp_event_kind;
   logic [7:0]            rsp_status_byte;
   logic [7:0]            rsp_first_data;
   logic [7:0]            rsp_second_data;
   logic [1:0]            rsp_data_count;
   logic [31:0]           rsp_delta_ticks;
   logic [23:0]           rsp_tempo_usec;
   logic [31:0]           rsp_sysex_length;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Decoder copy of the registers and the parse state
   bit          run_en   = 1'b1;
   bit          lead_en  = 1'b1;
   logic [23:0] trk_len  = '0;
   logic [23:0] trk_pos  = '0;
   phase_type   parse_at = PH_START;
   logic [7:0]  parse_cur = '0;
   logic [31:0] vlq_acc   = '0;
   logic [31:0] delta_acc = '0;
   logic [7:0]  held_byte = '0;
   logic [7:0]  meta_code = '0;
   logic [23:0] tempo_acc = '0;
   logic [31:0] skip_left = '0;
   bit          track_done = 1'b0;

   event_type   pending_events[$];
   event_type   want_ev;
   int          mismatches  = 0;
   int          bytes_sent  = 0;
   int          idle_cycles = 0;
   bit          quiet_run   = 1'b0;

   midi_track_event_parser DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_track_byte   (req_track_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_status_byte  (rsp_status_byte),
      .rsp_first_data   (rsp_first_data),
      .rsp_second_data  (rsp_second_data),
      .rsp_data_count   (rsp_data_count),
      .rsp_delta_ticks  (rsp_delta_ticks),
      .rsp_tempo_usec   (rsp_tempo_usec),
      .rsp_sysex_length (rsp_sysex_length),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Track decoder
   // ------------------------------------------------------------------------

   // Advance the byte position, holding at the top
   function automatic void step_pos();
      if (trk_pos != 24'hFFFFFF) trk_pos = trk_pos + 24'd1;
   endfunction

   // Shift one byte into the variable-length value; true once it is complete
   function automatic bit vlq_shift(input logic [7:0] b);
      step_pos();
      vlq_acc = {vlq_acc[24:0], b[6:0]};
      return !(b[7] && (trk_pos < trk_len));
   endfunction

   function automatic void restart_delta();
      parse_at = PH_DELTA;
      vlq_acc  = '0;
   endfunction

   // Queue one event with the ticks gathered so far, then clear them
   function automatic void queue_event(input kind_type kind, input logic [7:0] status,
                                       input logic [7:0] first, input logic [7:0] second,
                                       input logic [1:0] count, input logic [23:0] tempo,
                                       input logic [31:0] slen);
      event_type ev;
      ev.kind      = kind;
      ev.status    = status;
      ev.first     = first;
      ev.second    = second;
      ev.count     = count;
      ev.delta     = delta_acc;
      ev.tempo     = tempo;
      ev.sysex_len = slen;
      pending_events = {pending_events, ev};
      delta_acc = '0;
   endfunction

   function automatic void close_track();
      track_done = 1'b1;
      queue_event(KIND_END, 8'h00, 8'h00, 8'h00, 2'd0, 24'd0, 32'd0);
   endfunction

   // Decode one accepted track byte
   function automatic void decode_byte(input logic [7:0] b);
      bit          more;
      bit          taken;
      bit          is_meta;
      logic [3:0]  nib;
      logic [31:0] idx;
      logic [32:0] sum;
      if (track_done) return;
      if (parse_at == PH_START) begin
         vlq_acc  = '0;
         parse_at = lead_en ? PH_DELTA : PH_STATUS;
      end
      more = 1'b1;
      while (more) begin
         more = 1'b0;
         case (parse_at)
            PH_DELTA: begin
               if (vlq_shift(b)) begin
                  sum       = {1'b0, delta_acc} + {1'b0, vlq_acc};
                  delta_acc = sum[32] ? 32'hFFFFFFFF : sum[31:0];
                  vlq_acc   = '0;
                  parse_at  = PH_STATUS;
               end
            end
            PH_STATUS: begin
               // too few bytes left for an event: end here
               if ({1'b0, trk_pos} + 25'd3 > {1'b0, trk_len}) begin
                  close_track();
               end else begin
                  taken = 1'b0;
                  if (!run_en || b[7]) begin
                     parse_cur = b;
                     step_pos();
                     taken = 1'b1;
                  end
                  nib     = parse_cur[7:4];
                  vlq_acc = '0;
                  if (nib >= NIB_NOTE_OFF && nib < NIB_SYSTEM)
                     parse_at = PH_DATA1;
                  else if (nib == NIB_SYSTEM)
                     parse_at = (parse_cur == STATUS_META) ? PH_META_TYPE : PH_SYS_LEN;
                  else
                     parse_at = PH_DELTA;
                  // a byte not taken as status goes on to the next phase
                  if (!taken) more = 1'b1;
               end
            end
            PH_DATA1: begin
               step_pos();
               held_byte = b;
               nib = parse_cur[7:4];
               if (nib != NIB_PROG && nib != NIB_PRESS) begin
                  parse_at = PH_DATA2;
               end else begin
                  queue_event(KIND_CHAN, parse_cur, b, 8'h00, 2'd1, 24'd0, 32'd0);
                  restart_delta();
               end
            end
            PH_DATA2: begin
               step_pos();
               queue_event(KIND_CHAN, parse_cur, held_byte, b, 2'd2, 24'd0, 32'd0);
               restart_delta();
            end
            PH_META_TYPE: begin
               step_pos();
               meta_code = b;
               vlq_acc   = '0;
               parse_at  = PH_META_LEN;
            end
            PH_META_LEN, PH_SYS_LEN: begin
               is_meta = (parse_at == PH_META_LEN);
               if (vlq_shift(b)) begin
                  if ({9'd0, trk_pos} + {1'b0, vlq_acc} >= {9'd0, trk_len} ||
                      (is_meta && meta_code == META_END)) begin
                     close_track();
                  end else begin
                     skip_left = vlq_acc;
                     tempo_acc = '0;
                     if (is_meta && meta_code == META_TEMPO && vlq_acc == 32'd0)
                        queue_event(KIND_TEMPO, STATUS_META, 8'h00, 8'h00, 2'd0, 24'd0,
                                    32'd0);
                     else if (!is_meta && parse_cur == STATUS_SYSEX)
                        queue_event(KIND_SYSEX_START, parse_cur, 8'h00, 8'h00, 2'd0, 24'd0,
                                    vlq_acc);
                     if (vlq_acc != 32'd0) parse_at = PH_SKIP;
                     else restart_delta();
                  end
               end
            end
            PH_SKIP: begin
               step_pos();
               idx       = vlq_acc - skip_left;
               skip_left = skip_left - 32'd1;
               if (parse_cur == STATUS_SYSEX) begin
                  queue_event(KIND_SYSEX_BYTE, parse_cur, b, 8'h00, 2'd0, 24'd0, 32'd0);
               end else if (parse_cur == STATUS_META && meta_code == META_TEMPO &&
                            idx < 32'd3) begin
                  tempo_acc = tempo_acc | (24'(b) << (8 * (2 - idx)));
                  if (idx == 32'd2 || skip_left == 32'd0)
                     queue_event(KIND_TEMPO, STATUS_META, 8'h00, 8'h00, 2'd0, tempo_acc,
                                 32'd0);
               end
               if (skip_left == 32'd0) restart_delta();
            end
            default: begin
               restart_delta();
               more = 1'b1;
            end
         endcase
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result side: random stall, event check, watchdog
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_stall <= !reset && !quiet_run && ($urandom_range(0, 99) < 13);
   end

   task automatic report(input string field, input logic [31:0] got,
                         input logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t: mismatch on %s: got %h, want %h", $realtime, field, got, want);
   endtask

   // Compare each event beat with the oldest pending event
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            report("unexpected event", {29'd0, rsp_event_kind}, 32'd0);
         end else begin
            want_ev = pending_events.pop_front();
            if (rsp_event_kind !== want_ev.kind)
               report("event_kind", {29'd0, rsp_event_kind}, {29'd0, want_ev.kind});
            if (rsp_status_byte !== want_ev.status)
               report("status_byte", {24'd0, rsp_status_byte}, {24'd0, want_ev.status});
            if (rsp_first_data !== want_ev.first)
               report("first_data", {24'd0, rsp_first_data}, {24'd0, want_ev.first});
            if (rsp_second_data !== want_ev.second)
               report("second_data", {24'd0, rsp_second_data}, {24'd0, want_ev.second});
            if (rsp_data_count !== want_ev.count)
               report("data_count", {30'd0, rsp_data_count}, {30'd0, want_ev.count});
            if (rsp_delta_ticks !== want_ev.delta)
               report("delta_ticks", rsp_delta_ticks, want_ev.delta);
            if (rsp_tempo_usec !== want_ev.tempo)
               report("tempo_usec", {8'd0, rsp_tempo_usec}, {8'd0, want_ev.tempo});
            if (rsp_sysex_length !== want_ev.sysex_len)
               report("sysex_length", rsp_sysex_length, want_ev.sysex_len);
         end
      end
   end

   // End the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Send one track byte, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b);
      while (!quiet_run && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_track_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(b);
      bytes_sent++;
   endtask

   // Hold off until every pending event has come out and the pipe is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RUN_STATUS: run_en  = data[0];
         CSR_LEAD_DELTA: lead_en = data[0];
         CSR_TRACK_LEN:  trk_len = data[23:0];
         default: ;
      endcase
   endtask

   // Send a value in variable-length form, shortest encoding
   task automatic send_vlq(input logic [31:0] v);
      int n;
      n = 1;
      while (n < 5 && (v >> (7 * n)) != 32'd0) n++;
      for (int i = n - 1; i >= 0; i--)
         send_byte({(i != 0), 7'(v >> (7 * i))});
   endtask

   task automatic send_payload(input int len);
      send_vlq(len);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
   endtask

   // One well-formed event, status byte included unless running status applies
   task automatic send_random_event();
      int         pick;
      int         len;
      logic [7:0] st;
      logic [7:0] mt;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         if (run_en && parse_cur[7] && parse_cur[7:4] != NIB_SYSTEM &&
             $urandom_range(0, 2) == 0) begin
            st = parse_cur;
         end else begin
            st = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
            send_byte(st);
         end
         send_byte(8'($urandom_range(0, 127)));
         if (st[7:4] != NIB_PROG && st[7:4] != NIB_PRESS)
            send_byte(8'($urandom_range(0, 127)));
      end else if (pick < 60) begin
         send_byte(STATUS_META);
         send_byte(META_TEMPO);
         len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 5) : 3;
         send_payload(len);
      end else if (pick < 70) begin
         do mt = 8'($urandom_range(0, 255));
         while (mt == META_END || mt == META_TEMPO);
         send_byte(STATUS_META);
         send_byte(mt);
         send_payload($urandom_range(0, 4));
      end else if (pick < 85) begin
         send_byte(STATUS_SYSEX);
         len = ($urandom_range(0, 49) == 0) ? $urandom_range(128, 140)
                                            : $urandom_range(0, 10);
         send_payload(len);
      end else begin
         send_byte(8'($urandom_range(8'hF1, 8'hFE)));
         send_payload($urandom_range(0, 4));
      end
   endtask

   // Channel statuses and data in any order, then zeros until the next event start
   task automatic send_noise();
      send_byte({4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))});
      repeat ($urandom_range(0, 7)) send_byte(8'($urandom_range(0, 8'hEF)));
      while (!track_done && parse_at != PH_STATUS) send_byte(8'h00);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Channel, tempo and sysex events, running status and a zero-length tempo
   task automatic test_basic_messages();
      // absent status at the start opens a delta
      if (lead_en) send_vlq(32'd0);
      else send_byte(8'h05);
      send_byte(8'h90); send_byte(8'h00); send_byte(8'h7F);
      send_vlq(32'd127);
      send_byte(8'hC5); send_byte(8'h00);
      send_vlq(32'd0);
      send_byte(8'h7F);
      send_vlq(32'd0);
      send_byte(STATUS_META); send_byte(META_TEMPO); send_byte(8'h03);
      send_byte(8'h80); send_byte(8'h00); send_byte(8'hFF);
      send_vlq(32'h80);
      send_byte(STATUS_SYSEX); send_byte(8'h02); send_byte(8'hFF); send_byte(8'hF7);
      send_vlq(32'd0);
      send_byte(STATUS_META); send_byte(META_TEMPO); send_byte(8'h00);
      send_vlq(32'd0);
   endtask

   // Two deltas across a silent meta event overflow the tick sum
   task automatic test_delta_saturation();
      send_vlq(32'hFFFFFFFF);
      send_byte(STATUS_META); send_byte(8'h01); send_byte(8'h00);
      send_vlq(32'd1);
      send_byte(8'hE0); send_byte(8'h7F); send_byte(8'h7F);
      send_vlq(32'd0);
   endtask

   task automatic test_random_track(input bit use_running, input bit short_track,
                                    input bit no_idle);
      int start;
      write_csr(CSR_RUN_STATUS, CSR_DATA_W'(use_running));
      write_csr(CSR_LEAD_DELTA, CSR_DATA_W'($urandom_range(0, 1)));
      if (short_track)
         write_csr(CSR_TRACK_LEN, trk_pos + 24'd600 + 24'($urandom_range(0, 400)));
      else
         write_csr(CSR_TRACK_LEN, 24'hFFFFFF);
      quiet_run = no_idle;
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
         if ($urandom_range(0, 99) < 15) begin
            send_noise();
         end else begin
            send_random_event();
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9: send_vlq(32'd0);
               10, 11, 12, 13, 14, 15:       send_vlq($urandom_range(1, 127));
               16, 17:                       send_vlq($urandom_range(128, 16'h3FFF));
               18:                           send_vlq($urandom_range(0, 32'h0FFFFFFF));
               default:                      send_vlq($urandom());
            endcase
         end
         // drain the result side now and then
         if ($urandom_range(0, 199) == 0) settle();
      end
      quiet_run = 1'b0;
   endtask

   // End the track one way, then show that later bytes are dropped
   task automatic test_end_of_track();
      end_way_type way;
      way = end_way_type'($urandom_range(0, 4));
      case (way)
         END_META: begin
            send_byte(STATUS_META); send_byte(META_END); send_byte(8'h00);
         end
         END_META_OVERRUN: begin
            write_csr(CSR_TRACK_LEN, trk_pos + 24'd4);
            send_byte(STATUS_META); send_byte(8'h01); send_byte(8'h02);
         end
         END_SYSEX_OVERRUN: begin
            write_csr(CSR_TRACK_LEN, trk_pos + 24'd5);
            send_byte(STATUS_SYSEX); send_byte(8'h03);
         end
         END_AT_ZERO_LENGTH: begin
            // a delta stops at the end of the track despite bit 7
            send_byte(8'h90); send_byte(8'h40); send_byte(8'h40);
            write_csr(CSR_TRACK_LEN, 24'd0);
            send_byte(8'h81);
            send_byte(8'h90);
         end
         default: begin
            write_csr(CSR_TRACK_LEN, trk_pos + 24'd2);
            send_byte(8'h90);
         end
      endcase
      repeat (4) send_byte(8'($urandom_range(0, 255)));
      write_csr(CSR_TRACK_LEN, 24'd0);
      repeat (3) send_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_csr(CSR_TRACK_LEN, 24'hFFFFFF);
      write_csr(CSR_LEAD_DELTA, CSR_DATA_W'($urandom_range(0, 1)));
      write_csr(CSR_RUN_STATUS, CSR_DATA_W'(1));
      test_basic_messages();
      test_delta_saturation();
      test_random_track(1'b1, 1'b0, 1'b0);
      test_random_track(1'b0, 1'b1, 1'b0);
      test_random_track(1'b1, 1'b0, 1'b1);
      test_random_track(1'($urandom_range(0, 1)), 1'b0, 1'b0);
      test_end_of_track();
      settle();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
